>>> hw/rtl/tdpb_pkg.sv
// Shared types and constants for the tail-drop packet buffer timing block.
// No dependencies; every other file takes names from here by scope.
package tdpb_pkg;

    localparam int TDPB_DEPTH = 1024;
    localparam int BUF_SIZE_W = 11;
    localparam logic [BUF_SIZE_W-1:0] BUF_SIZE_RST = 11'd1024;

    localparam int TIME_W = 32;
    localparam int PROC_W = 16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_PUSH
    } t_state;

endpackage

>>> hw/rtl/tdpb_in_if.sv
// Input channel: one packet per beat (arrival and processing time).
// Depends on tdpb_pkg for field widths.
interface tdpb_in_if;
    logic                          valid;
    logic                          ready;
    logic [tdpb_pkg::TIME_W-1:0]   arr_tick;
    logic [tdpb_pkg::PROC_W-1:0]   proc_ticks;

    modport source (output valid, output arr_tick, output proc_ticks, input ready);
    modport sink   (input valid, input arr_tick, input proc_ticks, output ready);
endinterface

>>> hw/rtl/tdpb_out_if.sv
// Result channel: drop flag and start tick per beat.
// Depends on tdpb_pkg for field widths.
interface tdpb_out_if;
    logic                          valid;
    logic                          ready;
    logic                          dropped;
    logic [tdpb_pkg::TIME_W-1:0]   start_tick;

    modport source (output valid, output dropped, output start_tick, input ready);
    modport sink   (input valid, input dropped, input start_tick, output ready);
endinterface

>>> hw/rtl/tdpb_ring_mem.sv
// Finish-time ring storage: one write port, one read port, registered read data.
// Depends on tdpb_pkg for the data width.
module tdpb_ring_mem #(
    parameter int DEPTH = tdpb_pkg::TDPB_DEPTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [AW-1:0]               i_wr_addr,
    input  logic [tdpb_pkg::TIME_W-1:0] i_wr_data,
    input  logic [AW-1:0]               i_rd_addr,
    output logic [tdpb_pkg::TIME_W-1:0] o_rd_data
);

    logic [tdpb_pkg::TIME_W-1:0] r_mem [DEPTH];
    logic [tdpb_pkg::TIME_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/tdpb_ctrl.sv
// Sequencer for the packet buffer: pops expired entries, decides drop/start,
// pushes the finish time and holds the result beat. Depends on tdpb_pkg and the
// channel interfaces; drives the ring memory ports.
module tdpb_ctrl #(
    parameter int DEPTH = tdpb_pkg::TDPB_DEPTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [tdpb_pkg::BUF_SIZE_W-1:0] i_buffer_size,
    tdpb_in_if.sink                         i_pkt,
    tdpb_out_if.source                      o_res,
    output logic                            o_wr_en,
    output logic [AW-1:0]                   o_wr_addr,
    output logic [tdpb_pkg::TIME_W-1:0]     o_wr_data,
    output logic [AW-1:0]                   o_rd_addr,
    input  logic [tdpb_pkg::TIME_W-1:0]     i_rd_data
);

    localparam int OW = $clog2(DEPTH + 1);
    localparam int TW = OW + 1;
    localparam int TM = tdpb_pkg::TIME_W;

    tdpb_pkg::t_state r_state, n_state;

    logic [AW-1:0]                   r_head;
    logic [OW-1:0]                   r_occ;
    logic [TM-1:0]                   r_arrival;
    logic [tdpb_pkg::PROC_W-1:0]     r_proc;
    logic [TM-1:0]                   r_last;
    logic                            r_out_valid;
    logic                            r_dropped;
    logic [TM-1:0]                   r_start;

    logic          accept;
    logic          pop_hit;
    logic          out_free;
    logic          full;
    logic [AW-1:0] head_inc;
    logic [TW-1:0] tail_sum;
    logic [AW-1:0] tail;
    logic [TM-1:0] start;
    logic [TM:0]   finish_sum;
    logic [TM-1:0] finish;

    assign accept   = i_pkt.valid && i_pkt.ready;
    assign out_free = !r_out_valid || o_res.ready;
    assign pop_hit  = (r_occ != '0) && (i_rd_data <= r_arrival);
    assign head_inc = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);

    // capacity is min(buffer_size, DEPTH); occupancy never exceeds DEPTH
    assign full = (32'(r_occ) >= 32'(i_buffer_size)) || (r_occ == OW'(DEPTH));

    assign tail_sum = TW'(r_head) + TW'(r_occ);
    assign tail     = (tail_sum >= TW'(DEPTH)) ? AW'(tail_sum - TW'(DEPTH)) : AW'(tail_sum);

    assign start      = ((r_occ != '0) && (r_last > r_arrival)) ? r_last : r_arrival;
    assign finish_sum = {1'b0, start} + (TM + 1)'(r_proc);
    assign finish     = finish_sum[TM] ? '1 : finish_sum[TM-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tdpb_pkg::ST_IDLE: begin
                if (accept) n_state = tdpb_pkg::ST_POP;
            end
            tdpb_pkg::ST_POP: begin
                if (!pop_hit) n_state = tdpb_pkg::ST_PUSH;
            end
            tdpb_pkg::ST_PUSH: begin
                if (out_free) n_state = tdpb_pkg::ST_IDLE;
            end
            default: n_state = tdpb_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        i_pkt.ready = 1'b0;
        o_rd_addr   = r_head;
        o_wr_en     = 1'b0;
        unique case (r_state)
            tdpb_pkg::ST_IDLE: begin
                i_pkt.ready = 1'b1;
            end
            // read ahead at head+1 so a pop chain runs one entry per cycle
            tdpb_pkg::ST_POP: begin
                o_rd_addr = head_inc;
            end
            tdpb_pkg::ST_PUSH: begin
                o_wr_en = out_free && !full;
            end
            default: begin
                i_pkt.ready = 1'b0;
            end
        endcase
    end

    assign o_wr_addr = tail;
    assign o_wr_data = finish;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tdpb_pkg::ST_IDLE;
            r_head      <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == tdpb_pkg::ST_POP && pop_hit) begin
                r_head <= head_inc;
                r_occ  <= r_occ - OW'(1);
            end
            if (r_state == tdpb_pkg::ST_PUSH && out_free) begin
                r_out_valid <= 1'b1;
                if (!full) r_occ <= r_occ + OW'(1);
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_arrival <= i_pkt.arr_tick;
            r_proc    <= i_pkt.proc_ticks;
        end
        if (r_state == tdpb_pkg::ST_PUSH && out_free) begin
            r_dropped <= full;
            r_start   <= full ? '0 : start;
            if (!full) r_last <= finish;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.dropped    = r_dropped;
    assign o_res.start_tick = r_start;

`ifndef NO_ASSERTIONS
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OW'(DEPTH))
        else $error("occupancy above depth");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> (r_occ < OW'(DEPTH)) && (r_state == tdpb_pkg::ST_PUSH))
        else $error("push into a full ring");

    a_accept_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == tdpb_pkg::ST_POP)
        else $error("accepted beat did not start the expiry scan");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tdpb_pkg::ST_POP && pop_hit) |=> r_occ == $past(r_occ) - OW'(1))
        else $error("pop did not decrement occupancy");
`endif

endmodule

>>> hw/rtl/tail_drop_packet_buffer_timing.sv
// Tail-drop packet buffer timing. Each input beat is a packet (arrival, process
// time); each yields one result beat (dropped, start_time). One packet is in
// work at a time: it passes through the idle, pop and push states; in the pop
// state the single read port of the ring memory retires one expired entry per
// cycle until no stored finish time expires at its arrival. A new packet is
// taken while the previous result still waits in the output register; its push
// step then waits until that register is free. buffer_size may be written only
// while idle; values above DEPTH act as DEPTH.
module tail_drop_packet_buffer_timing #(
    parameter int DEPTH = tdpb_pkg::TDPB_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    tdpb_in_if.sink                         i_pkt,
    tdpb_out_if.source                      o_res,
    input  logic                            i_cfg_we,
    input  logic [tdpb_pkg::BUF_SIZE_W-1:0] i_cfg_wdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [tdpb_pkg::BUF_SIZE_W-1:0] r_buffer_size;

    logic                            wr_en;
    logic [AW-1:0]                   wr_addr;
    logic [tdpb_pkg::TIME_W-1:0]     wr_data;
    logic [AW-1:0]                   rd_addr;
    logic [tdpb_pkg::TIME_W-1:0]     rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_size <= tdpb_pkg::BUF_SIZE_RST;
        end else if (i_cfg_we) begin
            r_buffer_size <= i_cfg_wdata;
        end
    end

    tdpb_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_buffer_size (r_buffer_size),
        .i_pkt         (i_pkt),
        .o_res         (o_res),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_rd_addr     (rd_addr),
        .i_rd_data     (rd_data)
    );

    tdpb_ring_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule

>>> bench/tdpb_sched_checker.sv
`timescale 1ns / 100ps
// Checker for the tail-drop packet buffer: watches the packet, result and config ports,
// predicts each result and compares it. Depends on tdpb_pkg, tdpb_in_if and tdpb_out_if.
module tdpb_sched_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    tdpb_in_if                              i_pkt,
    tdpb_out_if                             i_res,
    input  logic                            i_cfg_we,
    input  logic [tdpb_pkg::BUF_SIZE_W-1:0] i_cfg_wdata,
    output int                              o_mismatches,
    output int                              o_pending
);

    localparam int HEAD_W = $clog2(tdpb_pkg::TDPB_DEPTH);
    localparam int PRINT_CAP = 100;

    typedef struct packed {
        logic                        dropped;
        logic [tdpb_pkg::TIME_W-1:0] start_tick;
    } t_outcome;

    logic [tdpb_pkg::TIME_W-1:0]     finish_ring [tdpb_pkg::TDPB_DEPTH];
    logic [HEAD_W-1:0]               ring_head;
    logic [tdpb_pkg::BUF_SIZE_W-1:0] ring_fill;
    logic [tdpb_pkg::BUF_SIZE_W-1:0] buf_limit;
    t_outcome                        awaited_outcomes [$];
    int                              mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    task automatic report_mismatch(input string what,
                                   input logic [tdpb_pkg::TIME_W-1:0] want,
                                   input logic [tdpb_pkg::TIME_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP) begin
            $display("[%0t] %s: expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    // Retire expired finish times, then either drop the packet or queue it behind
    // the newest finish time.
    function automatic t_outcome schedule_packet(input logic [tdpb_pkg::TIME_W-1:0] arrival,
                                                 input logic [tdpb_pkg::PROC_W-1:0] proc);
        t_outcome                        res;
        logic [tdpb_pkg::TIME_W:0]       finish;
        logic [tdpb_pkg::TIME_W-1:0]     newest;
        logic [tdpb_pkg::BUF_SIZE_W-1:0] cap;
        cap = (buf_limit > tdpb_pkg::BUF_SIZE_W'(tdpb_pkg::TDPB_DEPTH))
            ? tdpb_pkg::BUF_SIZE_W'(tdpb_pkg::TDPB_DEPTH) : buf_limit;
        while (ring_fill != 0 && finish_ring[ring_head] <= arrival) begin
            ring_head++;
            ring_fill--;
        end
        if (ring_fill >= cap) begin
            res.dropped = 1'b1;
            res.start_tick = '0;
        end else begin
            res.dropped = 1'b0;
            res.start_tick = arrival;
            if (ring_fill != 0) begin
                newest = finish_ring[HEAD_W'(ring_head + ring_fill - 1'b1)];
                if (newest > arrival) begin
                    res.start_tick = newest;
                end
            end
            finish = {1'b0, res.start_tick} + proc;
            finish_ring[HEAD_W'(ring_head + ring_fill)] =
                finish[tdpb_pkg::TIME_W] ? {tdpb_pkg::TIME_W{1'b1}}
                                         : finish[tdpb_pkg::TIME_W-1:0];
            ring_fill++;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            ring_head = '0;
            ring_fill = '0;
            buf_limit = tdpb_pkg::BUF_SIZE_RST;
            awaited_outcomes.delete();
        end else begin
            if (i_cfg_we) begin
                buf_limit = i_cfg_wdata;
            end
            if (i_res.valid && i_res.ready) begin
                if (awaited_outcomes.size() == 0) begin
                    report_mismatch("result beat with nothing outstanding", '0,
                                    i_res.start_tick);
                end else begin
                    want = awaited_outcomes[0];
                    awaited_outcomes.delete(0);
                    if (i_res.dropped !== want.dropped) begin
                        report_mismatch("dropped", tdpb_pkg::TIME_W'(want.dropped),
                                        tdpb_pkg::TIME_W'(i_res.dropped));
                    end
                    if (i_res.start_tick !== want.start_tick) begin
                        report_mismatch("start_tick", want.start_tick, i_res.start_tick);
                    end
                end
            end
            if (i_pkt.valid && i_pkt.ready) begin
                awaited_outcomes.insert(awaited_outcomes.size(),
                    schedule_packet(i_pkt.arr_tick, i_pkt.proc_ticks));
            end
        end
        o_pending <= awaited_outcomes.size();
    end

endmodule

>>> bench/tail_drop_packet_buffer_timing_tb.sv
`timescale 1ns / 100ps
// Top of the tail-drop packet buffer bench: clock, reset, packet stimulus, config writes and
// result back-pressure. Depends on tdpb_pkg, both interfaces, tdpb_sched_checker and the DUT.
module tail_drop_packet_buffer_timing_tb;

    localparam int STALL_LIMIT = 20000;
    localparam logic [tdpb_pkg::TIME_W-1:0] TICK_MAX = {tdpb_pkg::TIME_W{1'b1}};
    localparam logic [tdpb_pkg::PROC_W-1:0] PROC_MAX = {tdpb_pkg::PROC_W{1'b1}};

    typedef enum int {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_TRICKLE
    } t_rx_mode;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            cfg_we;
    logic [tdpb_pkg::BUF_SIZE_W-1:0] cfg_wdata;
    int                              mismatches;
    int                              pending;
    int                              burst_left = 0;
    logic [tdpb_pkg::TIME_W-1:0]     now_tick;
    t_rx_mode                        rx_mode = RX_FREE;
    int                              rx_mode_left = 0;

    tdpb_in_if  pkt_ch ();
    tdpb_out_if res_ch ();

    tail_drop_packet_buffer_timing uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pkt       (pkt_ch),
        .o_res       (res_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    tdpb_sched_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pkt        (pkt_ch),
        .i_res        (res_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result back-pressure: a mode is held for a random stretch, free-running included.
    always @(posedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_mode_left <= $urandom_range(16, 200);
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        case (rx_mode)
            RX_FREE:  res_ch.ready <= 1'b1;
            RX_LIGHT: res_ch.ready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY: res_ch.ready <= ($urandom_range(0, 2) == 0);
            default:  res_ch.ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    initial begin : watchdog
        int idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((pkt_ch.valid && pkt_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // One packet beat; valid then stays high until a gap, a config write or the end.
    task automatic send_packet(input logic [tdpb_pkg::TIME_W-1:0] arrival,
                               input logic [tdpb_pkg::PROC_W-1:0] proc);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 20);
            if (gap > 0) begin
                pkt_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        pkt_ch.valid <= 1'b1;
        pkt_ch.arr_tick <= arrival;
        pkt_ch.proc_ticks <= proc;
        do @(posedge i_clk); while (!pkt_ch.ready);
        burst_left--;
    endtask

    // Only written once every result is back; one result per packet, so the block is idle.
    task automatic set_buffer_size(input logic [tdpb_pkg::BUF_SIZE_W-1:0] size);
        pkt_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= size;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Mostly in-order arrivals with small steps, some long jumps that expire many
    // entries, and a few late beats that arrive at or before the current tick.
    task automatic run_phase(input logic [tdpb_pkg::BUF_SIZE_W-1:0] size, input int count,
                             input int unsigned step_max, input int unsigned jump_max,
                             input int unsigned proc_max);
        int                          roll;
        int unsigned                 step;
        int unsigned                 back;
        logic [tdpb_pkg::TIME_W-1:0] arrival;
        logic [tdpb_pkg::PROC_W-1:0] proc;
        set_buffer_size(size);
        repeat (count) begin
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
                back = $urandom_range(0, 64);
                arrival = (now_tick > back) ? now_tick - back : '0;
            end else begin
                step = (roll < 9) ? $urandom_range(0, jump_max) : $urandom_range(0, step_max);
                now_tick = (now_tick > TICK_MAX - step) ? TICK_MAX : now_tick + step;
                arrival = now_tick;
            end
            proc = ($urandom_range(0, 15) == 0) ? tdpb_pkg::PROC_W'($urandom())
                                                : tdpb_pkg::PROC_W'($urandom_range(0, proc_max));
            send_packet(arrival, proc);
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        pkt_ch.valid <= 1'b0;
        pkt_ch.arr_tick <= '0;
        pkt_ch.proc_ticks <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset capacity: zero-length jobs, longest job, backlog, saturating finish,
        // a late arrival behind the backlog, and a flush at the top tick.
        send_packet('0, '0);
        send_packet('0, PROC_MAX);
        send_packet(32'd10, 16'd5);
        send_packet(32'd65540, 16'd3);
        send_packet(TICK_MAX - 32'd15, PROC_MAX);
        send_packet(TICK_MAX - 32'd15, 16'd1);
        send_packet(32'd5, 16'd2);
        send_packet(TICK_MAX, '0);
        // No room at all: everything dropped, expired entries still retired
        set_buffer_size('0);
        send_packet(TICK_MAX, 16'd7);
        send_packet(32'd100, 16'd1);
        // Two slots: fill, drop, free one
        set_buffer_size(tdpb_pkg::BUF_SIZE_W'(2));
        send_packet(32'd100, 16'd50);
        send_packet(32'd100, 16'd50);
        send_packet(32'd100, 16'd50);
        send_packet(32'd150, 16'd10);
        // Capacity lowered under the current fill
        set_buffer_size(tdpb_pkg::BUF_SIZE_W'(1));
        send_packet(32'd160, 16'd1);
        send_packet(32'd205, 16'd4);
        send_packet(32'd210, 16'd4);

        now_tick = 32'd210;
        run_phase(tdpb_pkg::BUF_SIZE_W'(4), 100, 8, 4000, 24);
        // Above depth acts as depth: a long backlog with no expiry and no drops
        run_phase(tdpb_pkg::BUF_SIZE_W'(2047), 150, 0, 0, 40);
        run_phase('0, 20, 10, 4000, 12);
        // Far jump: the first beat retires every stored entry
        now_tick = 32'h8000_0000 | $urandom();
        run_phase(tdpb_pkg::BUF_SIZE_W'(1), 60, 10, 4000, 12);
        run_phase(tdpb_pkg::BUF_SIZE_W'(7), 100, 10, 4000, 30);
        run_phase(tdpb_pkg::BUF_SIZE_W'(1024), 100, 3, 4000, 200);
        run_phase(tdpb_pkg::BUF_SIZE_W'(64), 100, 20, 4000, 200);
        // Near the top tick, so finish times saturate
        now_tick = TICK_MAX - $urandom_range(0, 20000);
        run_phase(tdpb_pkg::BUF_SIZE_W'(5), 60, 300, 4000, PROC_MAX);

        pkt_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/tdpb_pkg.sv
hw/rtl/tdpb_in_if.sv
hw/rtl/tdpb_out_if.sv
hw/rtl/tdpb_ring_mem.sv
hw/rtl/tdpb_ctrl.sv
hw/rtl/tail_drop_packet_buffer_timing.sv
bench/tdpb_sched_checker.sv
bench/tail_drop_packet_buffer_timing_tb.sv
